[sv/hlcd_pkg.sv]
// Shared types and constants for the header/length/checksum deframer.
// Used by hlcd_ctrl, hlcd_dpath and the top level; no dependencies.
package hlcd_pkg;

    localparam int STORE_DEPTH_DEF = 32;
    localparam int LEN_W           = 5;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 5'd19;
    localparam logic [BYTE_W-1:0] MIN_LEN       = 8'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic start;     // header seen: restart frame with this byte
        logic put;       // store byte, bump count and sum
        logic set_len;   // latch frame length
        logic clear;     // parse ends: clear count, sum, read index
        logic rd_issue;  // read next stored byte for output
        logic load_err;  // load error result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hdr_match;
        logic len_ok;
        logic count_done;
        logic sum_match;
        logic rd_last;
        logic issue_ok;  // output register free next cycle, no read in flight
    } t_stat;

endpackage

[sv/hlcd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hlcd_dpath.sv]
// Deframer datapath: config registers, count/sum/length, frame store, output register.
// Depends on hlcd_pkg and hlcd_ram.
module hlcd_dpath
    import hlcd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output logic [BYTE_W-1:0]     o_frame_byte,
    output logic                  o_last_byte,
    output logic                  o_checksum_error
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [BYTE_W-1:0] r_header;
    logic [LEN_W-1:0]  r_max_len;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [LEN_W-1:0]  r_rd_idx;
    logic              r_rd_pend;
    logic              r_rd_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_err;

    logic [LEN_W+AW-1:0] wa_ext, ra_ext;
    logic [AW-1:0]       waddr, raddr;
    logic [BYTE_W-1:0]   rdata;
    logic                we;

    // config writes; unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER:  r_header  <= i_cfg_data;
                CFG_MAX_LEN: r_max_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (i_cmd.start) begin
            n_count = LEN_W'(1);
            n_sum   = i_rx_byte;
        end else if (i_cmd.put) begin
            n_count = r_count + LEN_W'(1);
            n_sum   = r_sum + i_rx_byte;
        end else if (i_cmd.clear) begin
            n_count = '0;
            n_sum   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_len     <= '0;
            r_rd_idx  <= '0;
            r_rd_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.set_len) begin
                r_len <= i_rx_byte[LEN_W-1:0];
            end
            if (i_cmd.clear) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_issue) begin
                r_rd_idx <= r_rd_idx + LEN_W'(1);
            end
            if (r_rd_pend || i_cmd.load_err) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_last <= o_stat.rd_last;
        end
        if (r_rd_pend) begin
            r_out_byte <= rdata;
            r_out_last <= r_rd_last;
            r_out_err  <= 1'b0;
        end else if (i_cmd.load_err) begin
            r_out_byte <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    // addresses always fall below STORE_DEPTH since length <= STORE_DEPTH
    assign wa_ext = {{AW{1'b0}}, (i_cmd.start ? LEN_W'(0) : r_count)};
    assign ra_ext = {{AW{1'b0}}, r_rd_idx};
    assign waddr  = wa_ext[AW-1:0];
    assign raddr  = ra_ext[AW-1:0];
    assign we     = i_cmd.start | i_cmd.put;

    hlcd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_stat.hdr_match  = (i_rx_byte == r_header);
        o_stat.len_ok     = (i_rx_byte >= MIN_LEN)
                          && (i_rx_byte <= {{(BYTE_W-LEN_W){1'b0}}, r_max_len})
                          && ({1'b0, i_rx_byte} <= (BYTE_W+1)'(STORE_DEPTH));
        o_stat.count_done = ({1'b0, r_count} + (LEN_W+1)'(1)) >= {1'b0, r_len};
        o_stat.sum_match  = (i_rx_byte == r_sum);
        o_stat.rd_last    = ((r_rd_idx + LEN_W'(1)) == r_len);
        o_stat.issue_ok   = (!r_out_valid || i_out_ready) && !r_rd_pend;
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_byte     = r_out_byte;
    assign o_last_byte      = r_out_last;
    assign o_checksum_error = r_out_err;

endmodule

[sv/hlcd_ctrl.sv]
// Deframer controller: hunt/length/payload/checksum parsing and frame dump sequencing.
// Depends on hlcd_pkg.
module hlcd_ctrl
    import hlcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_rx_valid,
    output logic  o_rx_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_LEN,
        S_DATA,
        S_CHK,
        S_EMIT,
        S_ERR
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_rx_ready = (r_state != S_EMIT) && (r_state != S_ERR);
    assign acc        = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (acc && i_stat.hdr_match) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LEN;
                end
            end
            S_LEN: begin
                if (acc) begin
                    if (i_stat.len_ok) begin
                        o_cmd.put     = 1'b1;
                        o_cmd.set_len = 1'b1;
                        n_state       = S_DATA;
                    end else begin
                        // rejected length is not rechecked as a header
                        o_cmd.clear = 1'b1;
                        n_state     = S_HUNT;
                    end
                end
            end
            S_DATA: begin
                if (acc) begin
                    o_cmd.put = 1'b1;
                    if (i_stat.count_done) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (acc) begin
                    o_cmd.clear = 1'b1;
                    n_state     = i_stat.sum_match ? S_EMIT : S_ERR;
                end
            end
            S_EMIT: begin
                if (i_stat.issue_ok) begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_ERR: begin
                if (i_stat.issue_ok) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = S_HUNT;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/header_length_checksum_deframer_core.sv]
// Length-prefixed frame receiver with 8-bit additive checksum.
// Input: one byte per cycle while parsing; ready is low while dumping a frame or error.
// Output: once the checksum byte is taken, each stored frame byte is read from the
// registered store and then loaded into the output register; one read is in flight
// at most; a read waits for a free output register, so output stall holds the dump.
// A bad sum gives the error result. Reset: control cleared, header 0xAA, max length 19.
module header_length_checksum_deframer_core
    import hlcd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_frame_byte,
    output logic                  o_last_byte,
    output logic                  o_checksum_error
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hlcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hlcd_dpath #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_rx_byte        (i_rx_byte),
        .i_out_ready      (i_out_ready),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_frame_byte     (o_frame_byte),
        .o_last_byte      (o_last_byte),
        .o_checksum_error (o_checksum_error)
    );

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_checksum_error |-> o_last_byte && (o_frame_byte == '0))
        else $error("error result with bad payload");

    a_no_rx_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rd_issue || cmd.load_err) |-> !o_rx_ready)
        else $error("input ready while dumping a frame");

    a_err_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_err |=> o_out_valid && o_checksum_error)
        else $error("error result not presented");

    a_byte_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_issue |=> ##1 o_out_valid && !o_checksum_error)
        else $error("frame byte not presented after read");

endmodule
